// File: sv/chd_pkg.sv
// Package for the chunked body decoder: phase, result and error codes,
// register indexes and the shared configuration and result types. No dependencies.
package chd_pkg;

   localparam int CSR_ADDR_BITS = 4;

   localparam logic [1:0] REG_MAX_CHUNK = 2'd0;
   localparam logic [1:0] REG_MAX_BODY  = 2'd1;
   localparam logic [1:0] REG_MAX_LINE  = 2'd2;

   localparam logic [23:0] MAX_CHUNK_RESET = 24'd1048576;
   localparam logic [31:0] MAX_BODY_RESET  = 32'd1048576;
   localparam logic [15:0] MAX_LINE_RESET  = 16'd4096;

   localparam logic [2:0] PH_SIZE    = 3'd0;
   localparam logic [2:0] PH_SIZE_LF = 3'd1;
   localparam logic [2:0] PH_DATA    = 3'd2;
   localparam logic [2:0] PH_TERM_CR = 3'd3;
   localparam logic [2:0] PH_TERM_LF = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;
   localparam logic [2:0] PH_ERR     = 3'd6;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic ERR_BAD   = 1'b0;
   localparam logic ERR_LARGE = 1'b1;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef struct packed {
      logic [23:0] chunk_size_limit;
      logic [31:0] max_body_size;
      logic [15:0] max_line_len;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic       error_code;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: sv/chd_if.sv
// Valid/ready channel interfaces for the decoder's request and result streams.
// No dependencies.
interface chd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       new_body;

   modport source (output valid, output rx_byte, output new_body, input ready);
   modport sink (input valid, input rx_byte, input new_body, output ready);
endinterface

interface chd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic       error_code;

   modport source (output valid, output kind, output payload_byte, output error_code,
                   input ready);
   modport sink (input valid, input kind, input payload_byte, input error_code,
                 output ready);
endinterface

// File: sv/chd_csr.sv
// Configuration registers of the chunked body decoder behind an APB-style port.
// Depends on chd_pkg.
module chd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [chd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output chd_pkg::cfg_type                 cfg
);
   import chd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[3:2];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_MAX_CHUNK: cfg_in.chunk_size_limit = pwdata[23:0];
            REG_MAX_BODY:  cfg_in.max_body_size    = pwdata;
            REG_MAX_LINE:  cfg_in.max_line_len     = pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAX_CHUNK: prdata = {8'd0, cfg_ff.chunk_size_limit};
         REG_MAX_BODY:  prdata = cfg_ff.max_body_size;
         REG_MAX_LINE:  prdata = {16'd0, cfg_ff.max_line_len};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_size_limit <= MAX_CHUNK_RESET;
         cfg_ff.max_body_size    <= MAX_BODY_RESET;
         cfg_ff.max_line_len     <= MAX_LINE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/chd_parser.sv
// Framing state machine of the chunked body decoder: parser state and the
// per-byte decision. Depends on chd_pkg.
module chd_parser #(
   parameter int CHUNK_SIZE_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic             new_body,
   input  chd_pkg::cfg_type cfg,
   output chd_pkg::rsp_type result
);
   import chd_pkg::*;

   localparam int CSB = CHUNK_SIZE_BITS;

   logic [2:0]     phase_ff, phase_in, phase_cur;
   logic [CSB-1:0] length_ff, length_in, length_cur;
   logic [CSB-1:0] position_ff, position_in, position_cur;
   logic [32:0]    total_ff, total_in, total_cur;
   logic [15:0]    line_ff, line_in, line_cur;
   logic           digit_ff, digit_in, digit_cur;

   hex_type        hex;
   logic [CSB+3:0] size_next;
   logic [32:0]    total_inc;
   logic [CSB-1:0] position_inc;

   always_comb begin
      phase_cur    = new_body ? PH_SIZE : phase_ff;
      length_cur   = new_body ? '0 : length_ff;
      position_cur = new_body ? '0 : position_ff;
      total_cur    = new_body ? '0 : total_ff;
      line_cur     = new_body ? '0 : line_ff;
      digit_cur    = new_body ? 1'b0 : digit_ff;

      hex          = hex_decode(rx_byte);
      size_next    = {length_cur, hex.value};
      total_inc    = total_cur + 33'd1;
      position_inc = position_cur + {{(CSB-1){1'b0}}, 1'b1};

      phase_in    = phase_cur;
      length_in   = length_cur;
      position_in = position_cur;
      total_in    = total_cur;
      line_in     = line_cur;
      digit_in    = digit_cur;
      result      = '{kind: KIND_FRAME, payload_byte: 8'd0, error_code: ERR_BAD};

      case (phase_cur)
         PH_SIZE: begin
            if (rx_byte == CHAR_CR) begin
               if (!digit_cur) begin
                  phase_in = PH_ERR;
                  result.kind = KIND_ERROR;
               end else begin
                  phase_in = PH_SIZE_LF;
               end
            end else if (!hex.valid) begin
               phase_in = PH_ERR;
               result.kind = KIND_ERROR;
            end else if (line_cur >= cfg.max_line_len) begin
               phase_in = PH_ERR;
               result.kind = KIND_ERROR;
               result.error_code = ERR_LARGE;
            end else begin
               line_in  = line_cur + 16'd1;
               digit_in = 1'b1;
               if (size_next[CSB+3:CSB] != 4'd0 ||
                   32'(size_next[CSB-1:0]) > 32'(cfg.chunk_size_limit)) begin
                  phase_in = PH_ERR;
                  result.kind = KIND_ERROR;
               end else begin
                  length_in = size_next[CSB-1:0];
               end
            end
         end
         PH_SIZE_LF: begin
            if (rx_byte != CHAR_LF) begin
               phase_in = PH_ERR;
               result.kind = KIND_ERROR;
            end else begin
               position_in = '0;
               line_in     = 16'd0;
               digit_in    = 1'b0;
               phase_in    = (length_cur == '0) ? PH_TERM_CR : PH_DATA;
            end
         end
         PH_DATA: begin
            total_in = total_inc;
            if (total_inc > {1'b0, cfg.max_body_size}) begin
               phase_in = PH_ERR;
               result.kind = KIND_ERROR;
               result.error_code = ERR_LARGE;
            end else begin
               position_in = position_inc;
               if (position_inc == length_cur) begin
                  phase_in = PH_TERM_CR;
               end
               result.kind = KIND_DATA;
               result.payload_byte = rx_byte;
            end
         end
         PH_TERM_CR: begin
            if (rx_byte != CHAR_CR) begin
               phase_in = PH_ERR;
               result.kind = KIND_ERROR;
            end else begin
               phase_in = PH_TERM_LF;
            end
         end
         PH_TERM_LF: begin
            if (rx_byte != CHAR_LF) begin
               phase_in = PH_ERR;
               result.kind = KIND_ERROR;
            end else if (length_cur == '0) begin
               phase_in = PH_DONE;
               result.kind = KIND_DONE;
            end else begin
               length_in   = '0;
               position_in = '0;
               line_in     = 16'd0;
               digit_in    = 1'b0;
               phase_in    = PH_SIZE;
            end
         end
         default: begin
            phase_in = phase_cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SIZE;
         length_ff   <= '0;
         position_ff <= '0;
         total_ff    <= '0;
         line_ff     <= '0;
         digit_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         total_ff    <= total_in;
         line_ff     <= line_in;
         digit_ff    <= digit_in;
      end
   end

endmodule

// File: sv/http_chunked_body_decoder_top.sv
// Decodes an HTTP chunked body one byte per request and gives exactly one result per
// request: framing, payload byte, body complete or error. A request is registered on
// entry, decoded by the framing state machine as it leaves the input register, and the
// result held in an output register; one request is accepted every cycle while results
// are taken. Throughput is set by the parser state, which is updated as each request
// moves to the output register. Configuration writes are taken at any time but should
// only be made while no request is in flight.
// Depends on chd_pkg, chd_if, chd_csr and chd_parser.
module http_chunked_body_decoder_top #(
   parameter int CHUNK_SIZE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   chd_req_if.sink                           req_bus,
   chd_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [chd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import chd_pkg::*;

   cfg_type    cfg;
   rsp_type    step_result;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_new_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   assign out_free       = !out_valid_ff || rsp_bus.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_bus.ready  = !reset && (!in_valid_ff || advance);
   assign req_take       = req_bus.valid && req_bus.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_ff.kind;
   assign rsp_bus.payload_byte = out_ff.payload_byte;
   assign rsp_bus.error_code   = out_ff.error_code;

   chd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   chd_parser #(
      .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .rx_byte  (in_byte_ff),
      .new_body (in_new_ff),
      .cfg      (cfg),
      .result   (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.rx_byte;
         in_new_ff  <= req_bus.new_body;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

endmodule

// File: tb/sv/http_chunked_body_decoder_top_test.sv
// Self-checking testbench for the chunked body decoder: requests, ready stalls and register
// writes are driven, and each result is checked against a predictor of the parser.
// Depends on chd_pkg, chd_if and http_chunked_body_decoder_top.
module http_chunked_body_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import chd_pkg::*;

   localparam int CHUNK_BITS = 24;
   localparam int LONG_HOLD = 200;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       new_body;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic [7:0] req_byte = 8'd0;
   logic       req_new = 1'b0;
   logic       rsp_ready = 1'b0;

   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0]              pwdata = 32'd0;
   logic [31:0]              prdata;
   logic                     pready;

   chd_req_if req_bus ();
   chd_rsp_if rsp_bus ();

   assign req_bus.valid = req_valid;
   assign req_bus.rx_byte = req_byte;
   assign req_bus.new_body = req_new;
   assign rsp_bus.ready = rsp_ready;

   http_chunked_body_decoder_top #(
      .CHUNK_SIZE_BITS(CHUNK_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stimulus and expectations.
   stream_byte_type pending[$];
   rsp_type         expected_results[$];
   int unsigned     bytes_queued = 0;
   int unsigned     results_seen = 0;
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   logic            fresh_body = 1'b0;
   logic            quiet = 1'b0;
   logic            req_taken = 1'b0;
   int unsigned     send_gap = 0;
   int unsigned     take_gap = 0;
   int unsigned     hold_left = 0;
   int unsigned     hold_asks = 0;
   int unsigned     hold_done = 0;

   // Shadow of the limit registers and of the parser state.
   cfg_type               limits = '{MAX_CHUNK_RESET, MAX_BODY_RESET, MAX_LINE_RESET};
   logic [2:0]            parse_phase = PH_SIZE;
   logic [CHUNK_BITS-1:0] chunk_len = '0;
   logic [CHUNK_BITS-1:0] chunk_pos = '0;
   logic [32:0]           payload_total = '0;
   logic [15:0]           line_len = '0;
   logic                  digit_seen = 1'b0;

   function automatic void restart_parser();
      parse_phase = PH_SIZE;
      chunk_len = '0;
      chunk_pos = '0;
      payload_total = '0;
      line_len = '0;
      digit_seen = 1'b0;
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic rsp_type parse_fault(input logic code);
      parse_phase = PH_ERR;
      return '{KIND_ERROR, 8'd0, code};
   endfunction

   function automatic rsp_type decode_byte(input logic [7:0] c, input logic restart);
      rsp_type                 r;
      int                      d;
      logic [CHUNK_BITS+3:0]   grown;
      r = '{KIND_FRAME, 8'd0, 1'b0};
      if (restart) restart_parser();
      case (parse_phase)
         PH_SIZE: begin
            if (c == CHAR_CR) begin
               if (!digit_seen) r = parse_fault(ERR_BAD);
               else parse_phase = PH_SIZE_LF;
            end else begin
               d = hex_value(c);
               if (d < 0) begin
                  r = parse_fault(ERR_BAD);
               end else if (line_len >= limits.max_line_len) begin
                  r = parse_fault(ERR_LARGE);
               end else begin
                  line_len = line_len + 16'd1;
                  digit_seen = 1'b1;
                  grown = {chunk_len, 4'(d)};
                  if (grown[CHUNK_BITS+3:CHUNK_BITS] != 4'd0) begin
                     r = parse_fault(ERR_BAD);
                  end else if (grown > (CHUNK_BITS+4)'(limits.chunk_size_limit)) begin
                     r = parse_fault(ERR_BAD);
                  end else begin
                     chunk_len = grown[CHUNK_BITS-1:0];
                  end
               end
            end
         end
         PH_SIZE_LF: begin
            if (c != CHAR_LF) begin
               r = parse_fault(ERR_BAD);
            end else begin
               chunk_pos = '0;
               line_len = '0;
               digit_seen = 1'b0;
               parse_phase = (chunk_len == '0) ? PH_TERM_CR : PH_DATA;
            end
         end
         PH_DATA: begin
            payload_total = payload_total + 33'd1;
            if (payload_total > {1'b0, limits.max_body_size}) begin
               r = parse_fault(ERR_LARGE);
            end else begin
               chunk_pos = chunk_pos + 1'b1;
               if (chunk_pos == chunk_len) parse_phase = PH_TERM_CR;
               r = '{KIND_DATA, c, 1'b0};
            end
         end
         PH_TERM_CR: begin
            if (c != CHAR_CR) r = parse_fault(ERR_BAD);
            else parse_phase = PH_TERM_LF;
         end
         PH_TERM_LF: begin
            if (c != CHAR_LF) begin
               r = parse_fault(ERR_BAD);
            end else if (chunk_len == '0) begin
               parse_phase = PH_DONE;
               r = '{KIND_DONE, 8'd0, 1'b0};
            end else begin
               chunk_len = '0;
               chunk_pos = '0;
               line_len = '0;
               digit_seen = 1'b0;
               parse_phase = PH_SIZE;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void report_mismatch(input string what, input rsp_type want,
                                           input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected kind %0d byte %02h code %0d, got kind %0d byte %02h code %0d",
                  what, want.kind, want.payload_byte, want.error_code,
                  got.kind, got.payload_byte, got.error_code);
   endfunction

   // Stream building.
   function automatic void queue_raw(input logic [7:0] b, input logic nb);
      pending.push_back('{b, nb});
      bytes_queued++;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      queue_raw(b, fresh_body);
      fresh_body = 1'b0;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic void push_crlf();
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 4'd10);
   endfunction

   function automatic void push_chunk(input int unsigned len);
      int unsigned nibbles;
      nibbles = 1;
      while (nibbles < 8 && (len >> (4 * nibbles)) != 0) nibbles++;
      if ($urandom_range(0, 3) == 0) nibbles += $urandom_range(1, 2);
      for (int i = int'(nibbles) - 1; i >= 0; i--) push_byte(hex_char(4'(len >> (4 * i))));
      push_crlf();
      repeat (len) push_byte(8'($urandom));
      push_crlf();
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 39);
      if (r == 0) return $urandom_range(49, 300);
      if (r < 8) return $urandom_range(17, 48);
      return $urandom_range(1, 16);
   endfunction

   function automatic void add_random_body();
      int unsigned     first;
      int unsigned     idx;
      stream_byte_type hit;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) queue_raw(8'($urandom), 1'($urandom));
      end else begin
         first = pending.size();
         fresh_body = 1'b1;
         repeat ($urandom_range(0, 3)) push_chunk(pick_length());
         push_chunk(0);
         if ($urandom_range(0, 7) == 0) begin
            idx = $urandom_range(first, pending.size() - 1);
            hit = pending[idx];
            hit.rx_byte = 8'($urandom);
            pending[idx] = hit;
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               if (pending.size() > first + 1) begin
                  void'(pending.pop_back());
                  bytes_queued--;
               end
            end
         end
      end
   endfunction

   // Register access: each write is followed by a read of the same register.
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'({index, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         REG_MAX_CHUNK: begin
            limits.chunk_size_limit = value[23:0];
            readback = {8'd0, value[23:0]};
         end
         REG_MAX_BODY: begin
            limits.max_body_size = value;
            readback = value;
         end
         default: begin
            limits.max_line_len = value[15:0];
            readback = {16'd0, value[15:0]};
         end
      endcase
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== readback) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch (register %0d read): expected %08h, got %08h",
                     index, readback, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_limits(input logic [23:0] chunk_cap, input logic [31:0] body_cap,
                             input logic [15:0] line_cap);
      write_reg(REG_MAX_CHUNK, {8'd0, chunk_cap});
      write_reg(REG_MAX_BODY, body_cap);
      write_reg(REG_MAX_LINE, {16'd0, line_cap});
   endtask

   task automatic wait_drained();
      while (results_seen != bytes_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Request driver.
   always @(negedge clock) begin : drive_requests
      stream_byte_type next_item;
      logic            offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         offer = 1'b0;
         if (send_gap != 0) begin
            send_gap--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 4);
         end else if (pending.size() != 0) begin
            next_item = pending.pop_front();
            req_byte <= next_item.rx_byte;
            req_new <= next_item.new_body;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // Result receiver, with random stalls and one long hold-off on request.
   always @(negedge clock) begin : drive_result_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (take_gap != 0) begin
         take_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         take_gap = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checking and prediction on each accepted request.
   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_bus.ready;
         if (rsp_bus.valid && rsp_ready) begin
            results_seen++;
            got = '{rsp_bus.kind, rsp_bus.payload_byte, rsp_bus.error_code};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) report_mismatch("result mismatch", want, got);
            end
         end
         if (req_valid && req_bus.ready)
            expected_results.push_back(decode_byte(req_byte, req_new));
      end
   end

   initial begin : run_test
      int unsigned target;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default limits: a complete body, whitespace, empty line, missing LF and a
      // wrong terminator after chunk data, with bytes ignored after the body and the space.
      fresh_body = 1'b1;
      push_text("1");
      push_crlf();
      push_byte(8'hFF);
      push_crlf();
      push_text("0");
      push_crlf();
      push_crlf();
      push_byte(8'h00);
      fresh_body = 1'b1;
      push_text(" x");
      fresh_body = 1'b1;
      push_byte(CHAR_CR);
      fresh_body = 1'b1;
      push_text("1");
      push_byte(CHAR_CR);
      push_text("Z");
      fresh_body = 1'b1;
      push_text("1");
      push_crlf();
      push_text("ab");
      wait_drained();

      // Tight body and line limits: a long size line and a body over its limit.
      set_limits(24'hFFFFFF, 32'd0, 16'd1);
      fresh_body = 1'b1;
      push_text("00");
      fresh_body = 1'b1;
      push_text("1");
      push_crlf();
      push_text("Q");
      wait_drained();

      // Widest limits: size overflow, a 0x prefix, a sign, a bare LF and a bad terminator
      // after the zero size line; then a chunk too big under small limits.
      set_limits(24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
      fresh_body = 1'b1;
      push_text("1000000");
      fresh_body = 1'b1;
      push_text("0x");
      fresh_body = 1'b1;
      push_text("-");
      fresh_body = 1'b1;
      push_byte(CHAR_LF);
      fresh_body = 1'b1;
      push_text("0");
      push_crlf();
      push_text("A");
      wait_drained();
      set_limits(24'd1, 32'd5, 16'd3);
      fresh_body = 1'b1;
      push_text("2");
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_limits(24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
            1: set_limits(24'd1, 32'd0, 16'd1);
            2: set_limits(MAX_CHUNK_RESET, MAX_BODY_RESET, MAX_LINE_RESET);
            default: set_limits(24'($urandom_range(1, 64)), $urandom_range(0, 2000),
                                16'($urandom_range(1, 4)));
         endcase
         quiet = (p == 7);
         target = bytes_queued + 160;
         while (bytes_queued < target) add_random_body();
         if (p == 4) hold_asks++;
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
